/* rtl/core/tcce_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants of the text console cell engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int COLS_DEFAULT = 80;
    localparam int ROWS_DEFAULT = 25;

    localparam logic [2:0] OP_PUT_CHAR   = 3'd0;
    localparam logic [2:0] OP_SET_CURSOR = 3'd1;
    localparam logic [2:0] OP_CLEAR      = 3'd2;
    localparam logic [2:0] OP_PUT_CELL   = 3'd3;
    localparam logic [2:0] OP_READ_CELL  = 3'd4;

    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] RESET_ATTR   = 8'h07;

    localparam logic [15:0] RESET_CELL = {RESET_ATTR, BLANK_CHAR};

    localparam logic CFG_TEXT_FG = 1'b0;
    localparam logic CFG_TEXT_BG = 1'b1;

    localparam logic [3:0] TEXT_FG_RESET = 4'd7;
    localparam logic [3:0] TEXT_BG_RESET = 4'd0;

    typedef struct packed {
        logic start;
        logic copy;
    } t_sweep_req;

endpackage
`default_nettype wire

/* rtl/core/tcce_cell_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_cell_store
// Cell memory with one write and one read port, plus a sweep engine that
// fills the store or scrolls it up one row and blanks the bottom row.
// ----------------------------------------------------------------------------
module tcce_cell_store #(
    parameter int COLS = tcce_pkg::COLS_DEFAULT,
    parameter int ROWS = tcce_pkg::ROWS_DEFAULT,
    localparam int CELLS = COLS * ROWS,
    localparam int AW = $clog2(CELLS)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire tcce_pkg::t_sweep_req i_sweep,
    input  wire logic [15:0]          i_fill,
    input  wire logic                 i_wr_en,
    input  wire logic [AW-1:0]        i_wr_addr,
    input  wire logic [15:0]          i_wr_data,
    input  wire logic [AW-1:0]        i_rd_addr,
    output logic [15:0]               o_rd_data,
    output logic                      o_busy
);

    localparam int COPY_END = CELLS - COLS;

    logic [15:0]   r_mem [CELLS];
    logic [15:0]   r_rd_data;
    logic          r_busy;
    logic          r_copy;
    logic [AW-1:0] r_cnt;
    logic [15:0]   r_fill;
    logic          r_wpend;
    logic          r_wcopy;
    logic [AW-1:0] r_waddr;

    logic          copy_rd;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;

    always_comb begin
        copy_rd = r_busy && r_copy && (r_cnt < AW'(COPY_END));
        rd_addr = copy_rd ? (r_cnt + AW'(COLS)) : i_rd_addr;
        wr_en   = r_wpend | i_wr_en;
        wr_addr = r_wpend ? r_waddr : i_wr_addr;
        wr_data = r_wpend ? (r_wcopy ? r_rd_data : r_fill) : i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_wcopy <= copy_rd;
        r_waddr <= r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_copy  <= 1'b0;
            r_cnt   <= '0;
            r_fill  <= tcce_pkg::RESET_CELL;
            r_wpend <= 1'b0;
        end else begin
            r_wpend <= r_busy;
            if (i_sweep.start) begin
                r_busy <= 1'b1;
                r_copy <= i_sweep.copy;
                r_cnt  <= '0;
                r_fill <= i_fill;
            end else if (r_busy) begin
                if (r_cnt == AW'(CELLS - 1)) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + AW'(1);
                end
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy | r_wpend;

endmodule
`default_nettype wire

/* rtl/core/text_console_cell_engine_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cell_engine_core
// Text console: cursor logic and command sequencer over a cell store.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tuser opcode, tdata char/col/row/fg/bg
// m_axis    out        tdata cursor col/row/linear, read cell, ignored
// i_cfg     in         write of text_fg (index 0) or text_bg (index 1)
//
// Put char (unless it scrolls), set cursor and put cell: accept, then execute.
// Read cell passes S_EXEC, S_READ and S_RESULT, as the cell memory read is registered.
// Clear and scroll sweep the memory one cell a cycle.
// After reset a clearing pass holds s_axis_tready low.
// A stalled result sits in the output register; the next request is accepted.
// ----------------------------------------------------------------------------
module text_console_cell_engine_core #(
    parameter int COLS = tcce_pkg::COLS_DEFAULT,
    parameter int ROWS = tcce_pkg::ROWS_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // char_code[7:0], col_in[14:8], row_in[19:15], cell_fg[23:20],
    // cell_bg[27:24], zero[31:28]
    input  wire logic [31:0] s_axis_tdata,
    // opcode[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // cursor_col[6:0], cursor_row[11:7], cursor_linear[22:12],
    // read_cell[38:23], ignored[39]
    output logic [39:0]      m_axis_tdata,
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_index,
    input  wire logic [3:0]  i_cfg_wdata
);

    localparam int CELLS = COLS * ROWS;
    localparam int AW = $clog2(CELLS);
    localparam int CW = $clog2(COLS);
    localparam int RW = $clog2(ROWS);
    localparam int LW = RW + 8;
    localparam logic [AW-1:0] COLS_A = AW'(COLS);
    localparam logic [CW:0] TAB_MASK = ~(CW + 1)'(3);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_READ   = 5'b00100,
        S_SWEEP  = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [3:0]    r_fg;
    logic [3:0]    r_bg;
    logic [2:0]    r_op;
    logic [7:0]    r_ch;
    logic [6:0]    r_cin;
    logic [4:0]    r_rin;
    logic [3:0]    r_cfg_fg;
    logic [3:0]    r_cfg_bg;
    logic [15:0]   r_rd;
    logic          r_ign, n_ign;
    logic          r_o_valid;
    logic [39:0]   r_o_data;

    logic          store_busy;
    logic [15:0]   store_rdata;
    tcce_pkg::t_sweep_req sweep;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;

    logic [7:0]    attr;
    logic [15:0]   blank;
    logic [AW-1:0] cur_addr;
    logic [AW-1:0] in_addr;
    logic          in_range;
    logic          do_nr;
    logic          read_go;
    logic [CW:0]   col_inc;
    logic [CW:0]   col_tab;
    logic [RW:0]   row_inc;
    logic          out_free;
    logic          out_load;
    logic [LW-1:0] lin;
    logic [15:0]   out_read;
    logic          out_ign;

    tcce_cell_store #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sweep   (sweep),
        .i_fill    (blank),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (in_addr),
        .o_rd_data (store_rdata),
        .o_busy    (store_busy)
    );

    always_comb begin
        attr     = {r_bg, r_fg};
        blank    = {attr, tcce_pkg::BLANK_CHAR};
        cur_addr = AW'(r_row) * COLS_A + AW'(r_col);
        in_addr  = AW'(r_rin) * COLS_A + AW'(r_cin);
        in_range = ({1'b0, r_cin} < 8'(COLS)) && ({2'b00, r_rin} < 7'(ROWS));
        col_inc  = {1'b0, r_col} + (CW + 1)'(1);
        col_tab  = ({1'b0, r_col} + (CW + 1)'(4)) & TAB_MASK;
        row_inc  = {1'b0, r_row} + (RW + 1)'(1);
        out_free = !r_o_valid || m_axis_tready;

        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_ign       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = cur_addr;
        wr_data     = {attr, r_ch};
        sweep.start = 1'b0;
        sweep.copy  = 1'b0;
        do_nr       = 1'b0;
        read_go     = 1'b0;
        out_load    = 1'b0;
        out_read    = r_rd;
        out_ign     = r_ign;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_op)
                    tcce_pkg::OP_PUT_CHAR: begin
                        case (r_ch)
                            tcce_pkg::CH_NEWLINE: begin
                                do_nr = 1'b1;
                            end
                            tcce_pkg::CH_RETURN: begin
                                n_col = '0;
                            end
                            tcce_pkg::CH_BACKSPACE: begin
                                if (r_col != '0) begin
                                    n_col   = r_col - CW'(1);
                                    wr_en   = 1'b1;
                                    wr_addr = cur_addr - AW'(1);
                                    wr_data = blank;
                                end
                            end
                            tcce_pkg::CH_TAB: begin
                                if (col_tab >= (CW + 1)'(COLS)) begin
                                    do_nr = 1'b1;
                                end else begin
                                    n_col = CW'(col_tab);
                                end
                            end
                            default: begin
                                wr_en = 1'b1;
                                if (col_inc >= (CW + 1)'(COLS)) begin
                                    do_nr = 1'b1;
                                end else begin
                                    n_col = CW'(col_inc);
                                end
                            end
                        endcase
                        if (do_nr) begin
                            n_col = '0;
                            if (row_inc >= (RW + 1)'(ROWS)) begin
                                n_row       = RW'(ROWS - 1);
                                sweep.start = 1'b1;
                                sweep.copy  = 1'b1;
                            end else begin
                                n_row = RW'(row_inc);
                            end
                        end
                    end
                    tcce_pkg::OP_SET_CURSOR: begin
                        if (in_range) begin
                            n_col = CW'(r_cin);
                            n_row = RW'(r_rin);
                        end else begin
                            n_ign = 1'b1;
                        end
                    end
                    tcce_pkg::OP_CLEAR: begin
                        n_col       = '0;
                        n_row       = '0;
                        sweep.start = 1'b1;
                    end
                    tcce_pkg::OP_PUT_CELL: begin
                        if (in_range) begin
                            wr_en   = 1'b1;
                            wr_addr = in_addr;
                            wr_data = {r_cfg_bg, r_cfg_fg, r_ch};
                        end else begin
                            n_ign = 1'b1;
                        end
                    end
                    tcce_pkg::OP_READ_CELL: begin
                        if (in_range) begin
                            read_go = 1'b1;
                        end else begin
                            n_ign = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                out_read = '0;
                out_ign  = n_ign;
                if (sweep.start) begin
                    n_state = S_SWEEP;
                end else if (read_go) begin
                    n_state = S_READ;
                end else if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_READ: begin
                n_state = S_RESULT;
            end
            S_SWEEP: begin
                if (!store_busy) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        lin = LW'(n_row) * LW'(COLS) + LW'(n_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_col     <= '0;
            r_row     <= '0;
            r_fg      <= tcce_pkg::TEXT_FG_RESET;
            r_bg      <= tcce_pkg::TEXT_BG_RESET;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    tcce_pkg::CFG_TEXT_FG: r_fg <= i_cfg_wdata;
                    tcce_pkg::CFG_TEXT_BG: r_bg <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op     <= s_axis_tuser;
            r_ch     <= s_axis_tdata[7:0];
            r_cin    <= s_axis_tdata[14:8];
            r_rin    <= s_axis_tdata[19:15];
            r_cfg_fg <= s_axis_tdata[23:20];
            r_cfg_bg <= s_axis_tdata[27:24];
        end
        if (r_state == S_EXEC) begin
            r_rd  <= '0;
            r_ign <= n_ign;
        end
        if (r_state == S_READ) begin
            r_rd <= store_rdata;
        end
        if (out_load) begin
            r_o_data <= {out_ign, out_read, 11'(lin), 5'(n_row), 7'(n_col)};
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && !store_busy;
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;

endmodule
`default_nettype wire

/* verif/text_console_cell_engine_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_engine_core_test
// Self-checking bench for the text console: requests carry console characters,
// cursor moves, clears, cell writes and cell reads. A shadow console with its
// own cell store and cursor predicts every result, and each returned result
// is compared field by field in order. Both stream sides stall at random, and
// the colour registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module text_console_cell_engine_core_test;
    import tcce_pkg::*;

    localparam int COLS = COLS_DEFAULT;
    localparam int ROWS = ROWS_DEFAULT;
    localparam int CELLS = COLS * ROWS;
    localparam int PHASE_ITEMS = 115;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 10_000_000;

    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    // bg/fg/row/col/char from the top down, matching s_axis_tdata
    typedef struct packed {
        logic [3:0] pad;
        logic [3:0] bg;
        logic [3:0] fg;
        logic [4:0] row;
        logic [6:0] col;
        logic [7:0] ch;
    } console_request_t;

    // matching m_axis_tdata
    typedef struct packed {
        logic        ignored;
        logic [15:0] read_cell;
        logic [10:0] linear;
        logic [4:0]  row;
        logic [6:0]  col;
    } console_result_t;

    class console_scoreboard;
        logic [15:0]     cells [CELLS];
        int unsigned     col_pos;
        int unsigned     row_pos;
        logic [3:0]      text_fg;
        logic [3:0]      text_bg;
        console_result_t pending_results [$];
        int unsigned     failures;
        int unsigned     requests;
        int unsigned     checked;
        int unsigned     scrolls;
        int unsigned     clears;
        int unsigned     out_of_range;
        int unsigned     reads;

        function new();
            foreach (cells[i]) cells[i] = RESET_CELL;
            col_pos = 0;
            row_pos = 0;
            text_fg = TEXT_FG_RESET;
            text_bg = TEXT_BG_RESET;
        endfunction

        function void set_colours(logic [3:0] fg, logic [3:0] bg);
            text_fg = fg;
            text_bg = bg;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function logic [15:0] blank_cell();
            return {text_bg, text_fg, BLANK_CHAR};
        endfunction

        function void advance_line();
            col_pos = 0;
            row_pos++;
            if (row_pos >= ROWS) begin
                for (int i = 0; i + COLS < CELLS; i++) cells[i] = cells[i + COLS];
                for (int i = CELLS - COLS; i < CELLS; i++) cells[i] = blank_cell();
                row_pos = ROWS - 1;
                scrolls++;
            end
        endfunction

        function void type_char(logic [7:0] ch);
            case (ch)
                CH_NEWLINE: advance_line();
                CH_RETURN: col_pos = 0;
                CH_BACKSPACE: begin
                    if (col_pos > 0) begin
                        col_pos--;
                        cells[row_pos * COLS + col_pos] = blank_cell();
                    end
                end
                CH_TAB: begin
                    col_pos = (col_pos + 4) & ~32'd3;
                    if (col_pos >= COLS) advance_line();
                end
                default: begin
                    cells[row_pos * COLS + col_pos] = {text_bg, text_fg, ch};
                    col_pos++;
                    if (col_pos >= COLS) advance_line();
                end
            endcase
        endfunction

        function void note_request(logic [2:0] op, console_request_t req);
            console_result_t res;
            bit              fits;
            res = '0;
            requests++;
            fits = req.col < COLS && req.row < ROWS;
            case (op)
                OP_PUT_CHAR: type_char(req.ch);
                OP_SET_CURSOR, OP_PUT_CELL, OP_READ_CELL: begin
                    if (!fits) begin
                        res.ignored = 1'b1;
                        out_of_range++;
                    end else if (op == OP_SET_CURSOR) begin
                        col_pos = req.col;
                        row_pos = req.row;
                    end else if (op == OP_PUT_CELL) begin
                        cells[req.row * COLS + req.col] = {req.bg, req.fg, req.ch};
                    end else begin
                        res.read_cell = cells[req.row * COLS + req.col];
                        reads++;
                    end
                end
                OP_CLEAR: begin
                    foreach (cells[i]) cells[i] = blank_cell();
                    col_pos = 0;
                    row_pos = 0;
                    clears++;
                end
                default: ;
            endcase
            res.col = 7'(col_pos);
            res.row = 5'(row_pos);
            res.linear = 11'(row_pos * COLS + col_pos);
            pending_results.push_back(res);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                failures++;
                $display("%0t: %s expected 0x%0h got 0x%0h", $time, field, want, got);
            end
        endfunction

        function void check_result(console_result_t got);
            console_result_t want;
            if (pending_results.size() == 0) begin
                failures++;
                $display("%0t: result 0x%0h with no request waiting", $time, got);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            compare_field("cursor_col", want.col, got.col);
            compare_field("cursor_row", want.row, got.row);
            compare_field("cursor_linear", want.linear, got.linear);
            compare_field("read_cell", want.read_cell, got.read_cell);
            compare_field("ignored", want.ignored, got.ignored);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        i_cfg_wr_en;
    logic        i_cfg_index;
    logic [3:0]  i_cfg_wdata;

    console_scoreboard book = new();
    bit                calm;
    int unsigned       sent;
    int unsigned       cycle_count;

    text_console_cell_engine_core #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) book.check_result(m_axis_tdata);
        m_axis_tready <= calm || ($urandom_range(99) >= 6);
    end

    function automatic console_request_t random_fields();
        console_request_t req;
        req.pad = '0;
        req.bg  = 4'($urandom_range(15));
        req.fg  = 4'($urandom_range(15));
        req.row = 5'($urandom_range(31));
        req.col = 7'($urandom_range(127));
        req.ch  = 8'($urandom_range(255));
        return req;
    endfunction

    function automatic console_request_t at_position(int unsigned col, int unsigned row);
        console_request_t req;
        req = random_fields();
        req.col = 7'(col);
        req.row = 5'(row);
        return req;
    endfunction

    function automatic console_request_t with_char(logic [7:0] ch);
        console_request_t req;
        req = random_fields();
        req.ch = ch;
        return req;
    endfunction

    task automatic send(logic [2:0] op, console_request_t req);
        if (!calm) begin
            while ($urandom_range(99) < 6) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        book.note_request(op, req);
        sent++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
    endtask

    task automatic set_colours(logic [3:0] fg, logic [3:0] bg);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_TEXT_FG;
        i_cfg_wdata <= fg;
        @(posedge i_clk);
        i_cfg_index <= CFG_TEXT_BG;
        i_cfg_wdata <= bg;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        book.set_colours(fg, bg);
    endtask

    // place the cursor, then type a burst of text with some control bytes
    task automatic typing_run();
        console_request_t req;
        int unsigned      col;
        int unsigned      row;
        int unsigned      r;
        col = ($urandom_range(3) == 0) ? $urandom_range(COLS - 1, COLS - 8)
                                       : $urandom_range(COLS - 1);
        row = ($urandom_range(2) == 0) ? ROWS - 1 : $urandom_range(ROWS - 1);
        send(OP_SET_CURSOR, at_position(col, row));
        repeat ($urandom_range(20, 3)) begin
            req = random_fields();
            r = $urandom_range(99);
            if (r < 8) req.ch = CH_NEWLINE;
            else if (r < 13) req.ch = CH_TAB;
            else if (r < 18) req.ch = CH_BACKSPACE;
            else if (r < 21) req.ch = CH_RETURN;
            else if (r < 85) req.ch = 8'($urandom_range(126, 32));
            send(OP_PUT_CHAR, req);
        end
    endtask

    task automatic noise_item();
        console_request_t req;
        logic [2:0]       op;
        int unsigned      r;
        req = random_fields();
        if ($urandom_range(4) != 0) begin
            req.col = 7'($urandom_range(COLS - 1));
            req.row = 5'($urandom_range(ROWS - 1));
        end
        r = $urandom_range(99);
        if (r < 20) op = OP_PUT_CHAR;
        else if (r < 35) op = OP_SET_CURSOR;
        else if (r < 58) op = OP_PUT_CELL;
        else if (r < 85) op = OP_READ_CELL;
        else if (r < 93) op = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
        else if (r < 96) op = OP_CLEAR;
        else begin
            op = OP_PUT_CHAR;
            req.ch = 8'($urandom_range(31));
        end
        send(op, req);
    endtask

    initial begin
        logic [3:0] fg_sel [4];
        logic [3:0] bg_sel [4];
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= OP_PUT_CHAR;
        s_axis_tdata  <= '0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= CFG_TEXT_FG;
        i_cfg_wdata   <= '0;
        calm = 1'b0;
        fg_sel = '{4'd15, 4'd0, 4'($urandom_range(15)), 4'd15};
        bg_sel = '{4'd0, 4'd15, 4'($urandom_range(15)), 4'd15};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send(OP_READ_CELL, at_position(0, 0));
        send(OP_PUT_CHAR, with_char(8'h41));
        send(OP_PUT_CHAR, with_char(8'hFF));
        send(OP_PUT_CHAR, with_char(8'h00));
        send(OP_PUT_CHAR, with_char(CH_BACKSPACE));
        send(OP_PUT_CHAR, with_char(CH_RETURN));
        send(OP_PUT_CHAR, with_char(CH_BACKSPACE));
        send(OP_PUT_CHAR, with_char(CH_TAB));
        send(OP_SET_CURSOR, at_position(COLS - 4, 0));
        send(OP_PUT_CHAR, with_char(CH_TAB));
        send(OP_SET_CURSOR, at_position(COLS - 1, ROWS - 1));
        send(OP_PUT_CHAR, with_char(8'h7E));
        send(OP_PUT_CHAR, with_char(CH_NEWLINE));
        send(OP_SET_CURSOR, at_position(127, 31));
        send(OP_SET_CURSOR, at_position(COLS, 0));
        send(OP_SET_CURSOR, at_position(0, ROWS));
        send(OP_PUT_CELL, '{pad: '0, bg: 4'hF, fg: 4'hF, row: 5'(ROWS - 1),
                            col: 7'(COLS - 1), ch: 8'hFF});
        send(OP_READ_CELL, at_position(COLS - 1, ROWS - 1));
        send(OP_PUT_CELL, at_position(127, 31));
        send(OP_READ_CELL, at_position(COLS - 1, 31));
        for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
            send(3'(op), random_fields());
        send(OP_CLEAR, random_fields());
        send(OP_READ_CELL, at_position(COLS / 2, ROWS / 2));

        for (int phase = 0; phase < 4; phase++) begin
            int unsigned target;
            settle();
            set_colours(fg_sel[phase], bg_sel[phase]);
            calm = (phase == 2);
            target = sent + PHASE_ITEMS;
            while (sent < target) begin
                if ($urandom_range(9) < 7) typing_run();
                else noise_item();
            end
        end

        settle();
        calm = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.pending() != 0) begin
            book.failures += book.pending();
            $display("%0t: %0d results never arrived", $time, book.pending());
        end
        $display("covered %0d requests, %0d results checked, %0d colour settings",
                 book.requests, book.checked, 4);
        $display("scrolls %0d, clears %0d, cell reads %0d, out-of-range positions %0d",
                 book.scrolls, book.clears, book.reads, book.out_of_range);
        if (book.failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* text_console_cell_engine_core.f */
rtl/core/tcce_pkg.sv
rtl/core/tcce_cell_store.sv
rtl/core/text_console_cell_engine_core.sv
verif/text_console_cell_engine_core_test.sv
